FILE: src/ttl_pkg.sv
package ttl_pkg;

  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int IDX_W      = 11;
  localparam int WORD_W     = 32;
  localparam int KEY_W      = WORD_W + 1;
  localparam int STEP_W     = 10;
  localparam int BASE_W     = 16;
  localparam int VALUE_W    = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FALLING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX   = 2'd3;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;
  localparam logic [BASE_W-1:0] BASE_RESET = 16'd0;
  localparam logic [IDX_W-1:0]  LAST_RESET = 11'd2047;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         entry_address;
    logic signed [WORD_W-1:0] entry_value;
    logic signed [WORD_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_q8;
    logic [IDX_W-1:0]          found_index;
    logic                      at_limit;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_FIRST,
    ST_FIRST,
    ST_FETCH,
    ST_STEP,
    ST_DIFF,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SUM
  } ctl_state_t;

  typedef enum logic [2:0] {
    WALK_NONE,
    WALK_UP,
    WALK_DOWN,
    WALK_EXACT,
    WALK_LIMIT,
    WALK_FRAC
  } walk_op_t;

  typedef struct packed {
    logic     write_entry;
    logic     load_sample;
    walk_op_t walk;
    logic     save_diff;
    logic     load_mul;
    logic     div_load;
    logic     div_step;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic key_gt;
    logic key_lt;
    logic at_top;
    logic at_zero;
    logic dir_up;
    logic frac;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/ttl_if.sv
interface ttl_item_if;
  import ttl_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttl_result_if;
  import ttl_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/ttl_ctrl.sv
module ttl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_cmd,
  output logic                item_ready,
  output ttl_pkg::dp_cmd_t    cmd,
  input  ttl_pkg::dp_status_t status
);
  import ttl_pkg::*;

  ctl_state_t state, state_next;
  walk_op_t   first_op, step_op, walk_op;
  logic       walk_end;

  // decision after the first compare fixes the direction
  always_comb begin
    if (status.key_gt) begin
      first_op = status.at_top ? WALK_LIMIT : WALK_UP;
    end else if (status.key_lt) begin
      first_op = status.at_zero ? WALK_LIMIT : WALK_DOWN;
    end else begin
      first_op = WALK_EXACT;
    end
  end

  always_comb begin
    if (status.dir_up) begin
      if (status.key_lt) begin
        step_op = WALK_FRAC;
      end else if (!status.key_gt) begin
        step_op = WALK_EXACT;
      end else begin
        step_op = status.at_top ? WALK_LIMIT : WALK_UP;
      end
    end else begin
      if (status.key_gt) begin
        step_op = WALK_FRAC;
      end else if (!status.key_lt) begin
        step_op = WALK_EXACT;
      end else begin
        step_op = status.at_zero ? WALK_LIMIT : WALK_DOWN;
      end
    end
  end

  assign walk_op  = (state == ST_FIRST) ? first_op : step_op;
  assign walk_end = (walk_op == WALK_EXACT) || (walk_op == WALK_LIMIT) ||
                    (walk_op == WALK_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && item_cmd == CMD_CONVERT) state_next = ST_FETCH_FIRST;
      end
      ST_FETCH_FIRST: state_next = ST_FIRST;
      ST_FIRST,
      ST_STEP: state_next = walk_end ? ST_DIFF : ST_FETCH;
      ST_FETCH: state_next = ST_STEP;
      ST_DIFF: state_next = ST_MUL;
      ST_MUL: state_next = status.frac ? ST_DIV_LOAD : ST_SUM;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready      = 1'b1;
        cmd.write_entry = item_valid && item_cmd == CMD_WRITE;
        cmd.load_sample = item_valid && item_cmd == CMD_CONVERT;
      end
      ST_FIRST,
      ST_STEP: cmd.walk = walk_op;
      ST_DIFF: cmd.save_diff = 1'b1;
      ST_MUL: cmd.load_mul = 1'b1;
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_SUM: cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: src/ttl_dp.sv
module ttl_dp #(
  parameter int TABLE_DEPTH = ttl_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = ttl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ttl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  ttl_pkg::in_item_t                   item,
  input  ttl_pkg::dp_cmd_t                    cmd,
  output ttl_pkg::dp_status_t                 status,
  output ttl_pkg::out_item_t                  result,
  output logic                                result_valid,
  input  logic                                result_ready
);
  import ttl_pkg::*;

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int QW     = STEP_W + FRAC_BITS;
  localparam int CW     = $clog2(QW);
  localparam int PROD_W = KEY_W + STEP_W;
  localparam int IPRD_W = IDX_W + STEP_W;
  localparam int WH_W   = IPRD_W + 2;

  function automatic logic signed [KEY_W-1:0] to_key(input logic signed [WORD_W-1:0] w,
                                                     input logic neg);
    logic signed [KEY_W-1:0] k;
    k = KEY_W'(w);
    return neg ? -k : k;
  endfunction

  // configuration
  logic                     falling_mode;
  logic [STEP_W-1:0]        step_size;
  logic signed [BASE_W-1:0] base_value;
  logic [IDX_W-1:0]         last_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      falling_mode <= 1'b0;
      step_size    <= STEP_RESET;
      base_value   <= BASE_RESET;
      last_index   <= LAST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FALLING_MODE: falling_mode <= cfg_data[0];
        REG_STEP_SIZE:    step_size    <= cfg_data[STEP_W-1:0];
        REG_BASE_VALUE:   base_value   <= cfg_data[BASE_W-1:0];
        REG_LAST_INDEX:   last_index   <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [IDX_W-1:0] top_idx;
  assign top_idx = (32'(last_index) > 32'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                            : last_index;

  // calibration table, one write port and one registered read port, usable in the same cycle
  logic [WORD_W-1:0]      mem [TABLE_DEPTH];
  logic [WORD_W-1:0]      rd_word;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W+AW-1:0]    rd_ext, wr_ext;
  logic                   wr_ok;

  assign rd_ext = {{AW{1'b0}}, idx};
  assign wr_ext = {{AW{1'b0}}, item.entry_address};
  assign wr_ok  = cmd.write_entry && (32'(item.entry_address) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_ok) mem[wr_ext[AW-1:0]] <= item.entry_value;
    rd_word <= mem[rd_ext[AW-1:0]];
  end

  // index walk
  logic signed [KEY_W-1:0] s_key, key_cur, prev_key, lo_key, hi_key;
  logic [IDX_W-1:0]        track;
  logic                    dir_up, frac, limit;

  assign key_cur = to_key(rd_word, falling_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      track <= '0;
    end else if (cmd.save_diff) begin
      track <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      s_key <= to_key(item.sample, falling_mode);
      idx   <= (track > top_idx) ? top_idx : track;
    end
    case (cmd.walk)
      WALK_UP: begin
        idx      <= idx + 1'b1;
        dir_up   <= 1'b1;
        prev_key <= key_cur;
      end
      WALK_DOWN: begin
        idx      <= idx - 1'b1;
        dir_up   <= 1'b0;
        prev_key <= key_cur;
      end
      WALK_EXACT: begin
        frac  <= 1'b0;
        limit <= 1'b0;
      end
      WALK_LIMIT: begin
        frac  <= 1'b0;
        limit <= 1'b1;
      end
      WALK_FRAC: begin
        frac  <= 1'b1;
        limit <= 1'b0;
        if (dir_up) begin
          // overshot by one: previous entry is the lower bracket
          lo_key <= prev_key;
          hi_key <= key_cur;
          idx    <= idx - 1'b1;
        end else begin
          lo_key <= key_cur;
          hi_key <= prev_key;
        end
      end
      default: ;
    endcase
  end

  // fraction: delta*step*2^frac / gap, radix-2 restoring division
  logic [KEY_W-1:0]  delta, gap, rem;
  logic [PROD_W-1:0] prod_f;
  logic [IPRD_W-1:0] prod_i;
  logic [QW-1:0]     nlo, quot;
  logic [CW-1:0]     cnt;
  logic [KEY_W:0]    trial;
  logic              fits;

  assign trial = {rem, nlo[QW-1]};
  assign fits  = trial >= {1'b0, gap};

  always_ff @(posedge clk) begin
    if (cmd.save_diff) begin
      delta <= s_key - lo_key;
      gap   <= hi_key - lo_key;
    end
    if (cmd.load_mul) begin
      prod_f <= PROD_W'(delta) * PROD_W'(step_size);
      prod_i <= IPRD_W'(idx) * IPRD_W'(step_size);
    end
    if (cmd.div_load) begin
      // upper part is already below gap since delta < gap and step < 2^STEP_W
      rem  <= prod_f[PROD_W-1:STEP_W];
      nlo  <= QW'(prod_f[STEP_W-1:0]) << FRAC_BITS;
      quot <= '0;
      cnt  <= CW'(QW - 1);
    end else if (cmd.div_step) begin
      rem  <= fits ? KEY_W'(trial - {1'b0, gap}) : trial[KEY_W-1:0];
      nlo  <= nlo << 1;
      quot <= {quot[QW-2:0], fits};
      cnt  <= cnt - 1'b1;
    end
  end

  // final sum and output register
  logic signed [WH_W-1:0] whole;
  logic [VALUE_W-1:0]     fpart, value;

  assign whole = WH_W'($signed({1'b0, prod_i})) + WH_W'(base_value);
  assign fpart = frac ? VALUE_W'(quot) : '0;
  assign value = (VALUE_W'(whole) << FRAC_BITS) + fpart;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.value_q8    <= value;
      result.found_index <= idx;
      result.at_limit    <= limit;
    end
  end

  assign status.key_gt   = s_key > key_cur;
  assign status.key_lt   = s_key < key_cur;
  assign status.at_top   = idx >= top_idx;
  assign status.at_zero  = idx == '0;
  assign status.dir_up   = dir_up;
  assign status.frac     = frac;
  assign status.div_last = cnt == '0;
  assign status.out_free = !result_valid || result_ready;

endmodule

FILE: src/tracking_table_interpolator.sv
// write item: stored on acceptance, the next beat is accepted on the following cycle
// convert item: a first table read and compare, then a registered table read and compare for
//   each entry walked, then difference, multiply, the divider only on a fraction, and the
//   output register load, which waits while a previous result is pending; one item at a time:
//   input held until the result is loaded; the divider yields one quotient bit per cycle
// rst (synchronous) restores register defaults and track index 0; table undefined until written
module tracking_table_interpolator #(
  parameter int TABLE_DEPTH = ttl_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = ttl_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  ttl_item_if.sink                       items,
  ttl_result_if.source                   results,
  input  logic                           cfg_write,
  input  logic [ttl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ttl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ttl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_cmd   (items.data.cmd),
    .item_ready (items.ready),
    .cmd        (cmd),
    .status     (status)
  );

  ttl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (items.data),
    .cmd          (cmd),
    .status       (status),
    .result       (results.data),
    .result_valid (results.valid),
    .result_ready (results.ready)
  );

`ifndef NO_ASSERTIONS
  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!results.valid || results.ready))
    else $error("result loaded over a pending beat");

  // a convert beat blocks the input until its result is built
  a_busy_after_convert: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.data.cmd == CMD_CONVERT) |=> !items.ready)
    else $error("input ready right after a convert beat");

  // table write and a conversion start never coincide
  a_single_start: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_entry && cmd.load_sample))
    else $error("write and convert started together");
`endif

endmodule
